>>> rtl/wmz_pkg.sv
package wmz_pkg;
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_UPD, S_DIVW, S_WMEAN, S_DIVK, S_WELF, S_MUL, S_DIVV, S_SQRT,
    S_DIVO, S_OUT
  } state_t;
  localparam logic [8:0] FALLBACK_LEN = 9'd128;
  localparam logic [11:0] OUT_MAX = 12'd2560;
  localparam int ADDR_WINDOW_LEN = 0;
endpackage

>>> rtl/wmz_ram.sv
module wmz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/wmz_div.sv
// Restoring divider, one quotient bit per cycle.
module wmz_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  assign trial = {rem, quo[63]} - {1'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        quo  <= num;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/window_mean_zscore_marker_core.sv
// Windowed z-score marker. Each price beat is stored in a ring window; from
// the third beat on each beat also updates a running Welford mean and squared
// deviation and one marker beat follows. Before m_tvalid rises, such a beat
// goes through five passes of the shared 64-step divider (window quotient,
// window fraction, Welford step, variance, output scale), a 32-step square
// root and a four-slice multiply; the count-of-one beat skips the variance
// pass and the root. The first two beats give no marker. s_tready stays low
// until the marker beat is taken.
// Window store has undefined contents after reset; only filled entries are read.
module window_mean_zscore_marker_core #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // price_sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata  // marker_size
);
  import wmz_pkg::*;
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int LW = AW + 1;

  state_t state, state_next;
  logic [8:0]  window_len;
  logic [AW-1:0] write_slot, slot;
  logic [LW-1:0] window_fill, n;
  logic [63:0] window_total, total_next;
  logic [1:0]  samples_seen;
  logic [31:0] stat_count;
  logic signed [63:0] running_mean, d;
  logic [63:0] running_sq_dev;
  logic [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [63:0] q_w, wmean, da, ea, prod, var_q, sd;
  logic [1:0]  mul_i;
  logic [5:0]  sq_i;
  logic [63:0] sq_v, sq_r;
  logic [11:0] outv;
  logic        full;
  logic [95:0] mul_part, mul_acc;
  logic [63:0] mul_sat, sq_sat;
  logic [64:0] sq_sum;

  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo, dv_rem;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = {23'd0, window_len};

  always_comb begin
    logic [31:0] wl;
    wl = (window_len < 9'd2) ? 32'(FALLBACK_LEN) : 32'(window_len);
    if (wl > 32'(WINDOW_MAX)) wl = 32'(WINDOW_MAX);
    n = LW'(wl);
  end

  assign slot = ({1'b0, write_slot} >= n) ? '0 : write_slot;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata = {4'd0, outv};
  assign total_next = window_total + 64'(x) - (full ? 64'(old_val) : 64'd0);

  wmz_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ram (
    .clk(clk), .we(state == S_UPD), .waddr(slot), .wdata(x),
    .raddr(slot), .rdata(old_val)
  );

  wmz_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  always_comb begin
    mul_part = 96'(da * 64'(ea[mul_i*16 +: 16])) << (mul_i * 16);
    mul_acc = 96'(prod) + mul_part;
    mul_sat = (mul_acc[95:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : mul_acc[63:0];
    sq_sum = 65'(running_sq_dev) + 65'(mul_sat);
    sq_sat = sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
  end

  // numerator is taken in the start cycle, divisor is held through the pass
  always_comb begin
    logic [63:0] xq, diff10;
    xq = 64'(x) << 24;
    diff10 = ((wmean > xq) ? wmean - xq : xq - wmean) * 64'd10;
    dv_num = '0;
    dv_den = 64'd1;
    unique case (state)
      S_UPD:   dv_num = total_next;
      S_DIVW:  begin dv_num = dv_rem << 24; dv_den = 64'(window_fill); end
      S_WMEAN: begin dv_num = d[63] ? -d : d; dv_den = 64'(window_fill); end
      S_DIVK:  dv_den = 64'(stat_count);
      S_MUL:   dv_num = (stat_count > 32'd1) ? sq_sat : diff10;
      S_DIVV:  dv_den = 64'(stat_count - 32'd1);
      S_SQRT:  dv_num = diff10;
      S_DIVO:  dv_den = sd << 8;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid && s_tready) state_next = S_RD;
      S_RD:    state_next = S_UPD;
      S_UPD:   state_next = (samples_seen >= 2'd2) ? S_DIVW : S_IDLE;
      S_DIVW:  if (dv_done) state_next = S_WMEAN;
      S_WMEAN: if (dv_done) state_next = S_DIVK;
      S_DIVK:  if (dv_done) state_next = S_WELF;
      S_WELF:  state_next = S_MUL;
      S_MUL:   if (mul_i == 2'd3) state_next = (stat_count > 32'd1) ? S_DIVV : S_DIVO;
      S_DIVV:  if (dv_done) state_next = S_SQRT;
      S_SQRT:  if (sq_i == 6'd31) state_next = S_DIVO;
      S_DIVO:  if (dv_done || sd == 64'd0) state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dv_start = 1'b0;
    unique case (state)
      S_UPD:   dv_start = (samples_seen >= 2'd2);
      S_DIVW:  dv_start = dv_done;
      S_WMEAN: dv_start = dv_done;
      S_MUL:   dv_start = (mul_i == 2'd3);
      S_SQRT:  dv_start = (sq_i == 6'd31);
      default: dv_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_len <= FALLBACK_LEN;
      write_slot <= '0;
      window_fill <= '0;
      window_total <= '0;
      samples_seen <= '0;
      stat_count <= '0;
      running_mean <= '0;
      running_sq_dev <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_wr) begin
        window_len <= pwdata[8:0];
        write_slot <= '0;
        window_fill <= '0;
        window_total <= '0;
      end
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) x <= s_tdata[SAMPLE_BITS-1:0];
        S_RD: begin
          full <= (window_fill >= n);
          if (window_fill < n) window_fill <= window_fill + 1'b1;
        end
        S_UPD: begin
          window_total <= total_next;
          write_slot <= ({1'b0, slot} + 1'b1 >= n) ? '0 : AW'({1'b0, slot} + 1'b1);
          if (samples_seen != 2'd3) samples_seen <= samples_seen + 2'd1;
          if (samples_seen >= 2'd2 && stat_count != 32'hFFFF_FFFF)
            stat_count <= stat_count + 32'd1;
          d <= (64'(x) << 24) - running_mean;
        end
        S_DIVW: if (dv_done) q_w <= dv_quo;
        S_WMEAN: if (dv_done) wmean <= (q_w << 24) + dv_quo;
        S_DIVK: if (dv_done) begin
          running_mean <= running_mean + (d[63] ? -dv_quo : dv_quo);
          da <= (d[63] ? -d : d) >> 16;
        end
        S_WELF: begin
          logic signed [63:0] e;
          e = (64'(x) << 24) - running_mean;
          ea <= (e[63] ? -e : e) >> 16;
          prod <= '0;
          mul_i <= '0;
        end
        S_MUL: begin
          prod <= mul_sat;
          if (mul_i == 2'd3) begin
            running_sq_dev <= sq_sat;
            if (stat_count <= 32'd1) sd <= 64'd256;
          end
          mul_i <= mul_i + 2'd1;
        end
        S_DIVV: if (dv_done) begin
          var_q <= dv_quo; sq_v <= dv_quo; sq_r <= '0; sd <= '0; sq_i <= '0;
        end
        S_SQRT: begin
          logic [65:0] rr, t;
          rr = {sq_r, sq_v[63:62]};
          t = rr - {sd, 2'b01};
          if (!t[65]) begin sq_r <= t[63:0]; sd <= {sd[62:0], 1'b1}; end
          else begin sq_r <= rr[63:0]; sd <= {sd[62:0], 1'b0}; end
          sq_v <= {sq_v[61:0], 2'b00};
          sq_i <= sq_i + 6'd1;
        end
        S_DIVO: begin
          if (sd == 64'd0) outv <= '0;
          else if (dv_done)
            outv <= (dv_quo > 64'(OUT_MAX)) ? OUT_MAX : dv_quo[11:0];
        end
        S_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = ^{var_q, pwdata[31:9], paddr[1:0]};
endmodule

>>> rtl/wmz_checker.sv
module wmz_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 16'd2560) else $error("range");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("busy");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("excl");
endmodule

bind window_mean_zscore_marker_core wmz_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> bench/window_mean_zscore_marker_core_tb.sv
module window_mean_zscore_marker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmz_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [23:0] price_sample
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [11:0] marker_size, rest zero

  window_mean_zscore_marker_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  localparam int DRAIN_CYCLES = 400;
  localparam int UNUSED_ADDR  = 4;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] value;
    bit          typed;
    logic [11:0] marker;
  } row_t;

  // model state
  logic [8:0]  len_reg;
  logic [23:0] ring [256];
  int unsigned slot_ptr;
  int unsigned fill;
  longint unsigned total;
  int unsigned seen;
  int unsigned kcount;
  longint      mean_q;
  longint unsigned sq_dev;

  logic [11:0] marker_q[$];
  int          errors;
  int          beats_out;
  bit          hold_req;
  bit          no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'd0 - longint'(unsigned'(a)) : unsigned'(a);
  endfunction

  task automatic len_write(logic [2:0] a, logic [31:0] v);
    if (a == ADDR_WINDOW_LEN) begin
      len_reg = v[8:0];
      slot_ptr = 0;
      fill = 0;
      total = 0;
    end
  endtask

  task automatic marker_predict(logic [23:0] x, output bit has, output logic [11:0] mk);
    int unsigned n, s;
    bit act;
    longint unsigned q, r, wmean, xm, da, ea, prod, sd, diff, o;
    longint d, e;
    n = (len_reg < 2) ? FALLBACK_LEN : len_reg;
    if (n > 256) n = 256;
    s = slot_ptr;
    if (s >= n) s = 0;
    if (fill < n) fill++;
    else total -= ring[s];
    ring[s] = x;
    total += x;
    s++;
    if (s >= n) s = 0;
    slot_ptr = s;
    act = seen >= 2;
    if (seen < 3) seen++;
    has = act;
    mk = '0;
    if (!act) return;
    q = total / fill;
    r = total % fill;
    wmean = (q << 24) + ((r << 24) / fill);
    xm = longint'(x) << 24;
    if (kcount != 32'hFFFF_FFFF) kcount++;
    d = longint'(xm) - mean_q;
    mean_q += d / longint'(kcount);
    e = longint'(xm) - mean_q;
    da = mag(d) >> 16;
    ea = mag(e) >> 16;
    if (da != 0 && ea > 64'hFFFF_FFFF_FFFF_FFFF / da) prod = 64'hFFFF_FFFF_FFFF_FFFF;
    else prod = da * ea;
    if (sq_dev > 64'hFFFF_FFFF_FFFF_FFFF - prod) sq_dev = 64'hFFFF_FFFF_FFFF_FFFF;
    else sq_dev += prod;
    if (kcount > 1) sd = isqrt(sq_dev / (kcount - 1));
    else sd = 256;
    if (sd != 0) begin
      diff = wmean > xm ? wmean - xm : xm - wmean;
      o = (diff * 10) / (sd * 256);
      if (o > OUT_MAX) o = OUT_MAX;
      mk = o[11:0];
    end
  endtask

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  task automatic apb_write(logic [2:0] a, logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    len_write(a, v);
  endtask

  task automatic settle();
    while (marker_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send(logic [23:0] x, bit typed, logic [11:0] tv);
    bit has;
    logic [11:0] mk;
    int g;
    s_tvalid <= 1;
    s_tdata <= x;
    do @(posedge clk); while (!s_tready);
    marker_predict(x, has, mk);
    if (has) marker_q.push_back(typed ? tv : mk);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic cfg_phase(logic [2:0] a, logic [31:0] v);
    s_tvalid <= 0;
    @(posedge clk);
    settle();
    apb_write(a, v);
  endtask

  // receiver
  initial begin
    int g;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 0;
        repeat (3000) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (marker_q.size() == 0) begin
        $display("%0t unexpected marker beat: expected none, actual %0d", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== {4'd0, marker_q[0]}) begin
          $display("%0t marker_size: expected %0d, actual %0d", $time, marker_q[0], m_tdata);
          errors++;
        end
        void'(marker_q.pop_front());
      end
    end
  end

  initial begin
    row_t dir[$];
    logic [23:0] base, x;
    int unsigned lens[7];
    int p;
    errors = 0; beats_out = 0; hold_req = 0; no_idle = 0;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0;
    len_reg = FALLBACK_LEN; slot_ptr = 0; fill = 0; total = 0;
    seen = 0; kcount = 0; mean_q = 0; sq_dev = 0;
    foreach (ring[i]) ring[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // constant run: first two silent, third has sd of one and zero distance,
    // then zero deviation
    dir.push_back('{0, 0, 1000, 0, 0});
    dir.push_back('{0, 0, 1000, 0, 0});
    dir.push_back('{0, 0, 1000, 1, 0});
    dir.push_back('{0, 0, 1000, 1, 0});
    dir.push_back('{0, 0, 1000, 1, 0});
    dir.push_back('{0, 0, 24'hFFFFFF, 0, 0});
    dir.push_back('{0, 0, 0, 0, 0});
    dir.push_back('{0, 0, 24'hFFFFFF, 0, 0});
    dir.push_back('{1, 3'(ADDR_WINDOW_LEN), 0, 0, 0});
    dir.push_back('{0, 0, 24'h800000, 0, 0});
    dir.push_back('{0, 0, 1, 0, 0});
    dir.push_back('{1, 3'(ADDR_WINDOW_LEN), 2, 0, 0});
    dir.push_back('{0, 0, 24'h555555, 0, 0});
    dir.push_back('{0, 0, 24'hAAAAAA, 0, 0});
    dir.push_back('{0, 0, 24'h555555, 0, 0});
    dir.push_back('{1, 3'(UNUSED_ADDR), 5, 0, 0});
    dir.push_back('{0, 0, 24'hAAAAAA, 0, 0});
    dir.push_back('{1, 3'(ADDR_WINDOW_LEN), 9'h1FF, 0, 0});
    dir.push_back('{0, 0, 24'h000100, 0, 0});
    dir.push_back('{0, 0, 24'hFFFFFF, 0, 0});
    dir.push_back('{1, 3'(ADDR_WINDOW_LEN), 1, 0, 0});
    dir.push_back('{0, 0, 24'h123456, 0, 0});
    dir.push_back('{0, 0, 24'h123457, 0, 0});
    foreach (dir[i]) begin
      if (dir[i].is_cfg) cfg_phase(dir[i].addr, dir[i].value);
      else send(dir[i].value[23:0], dir[i].typed, dir[i].marker);
    end

    lens = '{3, 256, 2, 511, 0, 17, 1};
    foreach (lens[ph]) begin
      cfg_phase(3'(ADDR_WINDOW_LEN), (ph == 5) ? $urandom_range(4, 255) : lens[ph]);
      no_idle = (ph == 2);
      base = 24'($urandom);
      x = base;
      for (int i = 0; i < 55; i++) begin
        if (ph == 1 && i == 10) hold_req = 1;
        p = $urandom_range(99);
        if (p < 60) x = 24'(base + ($urandom & ((1 << $urandom_range(1, 20)) - 1)));
        else if (p < 80) x = 24'($urandom);
        send(x, 0, 0);
      end
    end
    no_idle = 0;
    s_tvalid <= 0;
    @(posedge clk);
    settle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
